[src/dsc_pkg.sv]
// shared types and constants for the distinct subsequence counter
// no dependencies; imported by every module of the block
package dsc_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int COUNT_W = 64;
	localparam int SYM_W = 8;
	localparam int LEN_W = 7;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_FEED    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t             command;
		logic [SYM_W-1:0] symbol;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic               overflowed;
		logic [LEN_W-1:0]   pattern_length;
		logic               rejected;
	} result_t;

	// broadcast to every cell, already qualified by the accepted request
	typedef struct packed {
		logic             zero_counts;
		logic             append;
		logic             feed;
		logic [SYM_W-1:0] symbol;
	} cell_ctrl_t;

endpackage

[src/dsc_cell.sv]
// one pattern position: stored byte and saturating prefix count
// depends on dsc_pkg; instantiated in a chain by the top level
module dsc_cell #(
	parameter int IDX = 0,
	parameter int LW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dsc_pkg::cell_ctrl_t         ctrl,
	input  logic [LW-1:0]               count_len,
	input  logic [LW-1:0]               next_len,
	input  logic [dsc_pkg::COUNT_W-1:0] prev_count,
	output logic [dsc_pkg::COUNT_W-1:0] count,
	output logic [dsc_pkg::COUNT_W-1:0] sel_count,
	output logic                        ovf
);
	import dsc_pkg::*;

	localparam logic [LW-1:0] IDX_L = LW'(IDX);
	localparam logic [LW-1:0] IDX_N = LW'(IDX + 1);

	logic [SYM_W-1:0]   char_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W:0]   sum;
	logic               active;
	logic               tail;
	logic               hit;

	assign active = IDX_L < count_len;
	assign tail = count_len == IDX_L;
	assign hit = ctrl.feed && active && (char_q == ctrl.symbol);
	assign sum = {1'b0, count_q} + {1'b0, prev_count};

	always_comb begin
		count_next = count_q;
		if (ctrl.zero_counts || (ctrl.append && tail)) begin
			count_next = '0;
		end else if (hit) begin
			count_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.append && tail) begin
			char_q <= ctrl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign count = count_q;
	// only the cell that ends the pattern after this request drives the result
	assign sel_count = (next_len == IDX_N) ? count_next : '0;
	assign ovf = hit && sum[COUNT_W];

endmodule

[src/dsc_skid.sv]
// result register with one skid entry
// depends on dsc_pkg; used by the top level
module dsc_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dsc_pkg::result_t push_data,
	output logic             full,
	output logic             result_valid,
	input  logic             result_stall,
	output dsc_pkg::result_t result
);
	import dsc_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    taken;

	assign taken = out_v_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (taken) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= push;
				end
			end else if (out_v_q) begin
				if (push) begin
					skid_v_q <= 1'b1;
				end
			end else begin
				out_v_q <= push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (taken && skid_v_q) begin
			out_q <= skid_q;
		end else if (push && (taken || !out_v_q)) begin
			out_q <= push_data;
		end
		if (push && out_v_q && !taken) begin
			skid_q <= push_data;
		end
	end

	assign full = skid_v_q;
	assign result_valid = out_v_q;
	assign result = out_q;

endmodule

[src/distinct_subsequence_counter.sv]
// top level of the distinct subsequence counter
// depends on dsc_pkg, dsc_cell and dsc_skid
//
// One request is taken per clock while item_stall is low: every pattern position
// is a cell that updates from its left neighbor's old count in the same cycle, and
// the result of each source byte, append, clear or restart is registered in the
// output register, or in the skid entry while a result waits. An output register plus
// one skid entry let a request be taken while a result waits; item_stall rises only
// when both are occupied. The full-pattern count is picked from the chain by a
// one-hot select over the cells. Reset clears all counts at once; no clearing pass.
module distinct_subsequence_counter #(
	parameter int MAX_PATTERN = dsc_pkg::MAX_PATTERN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  dsc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output dsc_pkg::result_t result
);
	import dsc_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam logic [LW-1:0] FULL_LEN = LW'(MAX_PATTERN);

	logic [LW-1:0]      len_q;
	logic [LW-1:0]      len_next;
	logic               flag_q;
	logic               flag_next;
	logic               accept;
	logic               full;
	logic               rejected;
	cell_ctrl_t         ctrl;
	logic [COUNT_W-1:0] prev [MAX_PATTERN];
	logic [COUNT_W-1:0] cnt [MAX_PATTERN];
	logic [COUNT_W-1:0] sel [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] ovf;
	logic [COUNT_W-1:0] picked;
	logic               any_ovf;
	result_t            res;

	assign accept = item_valid && !item_stall;
	assign full = len_q == FULL_LEN;

	always_comb begin
		ctrl = '0;
		ctrl.symbol = item.symbol;
		len_next = len_q;
		rejected = 1'b0;
		if (accept) begin
			unique case (item.command)
				CMD_CLEAR: begin
					ctrl.zero_counts = 1'b1;
					len_next = '0;
				end
				CMD_APPEND: begin
					if (full) begin
						rejected = 1'b1;
					end else begin
						ctrl.append = 1'b1;
						len_next = len_q + LW'(1);
					end
				end
				CMD_RESTART: begin
					ctrl.zero_counts = 1'b1;
				end
				CMD_FEED: begin
					ctrl.feed = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign prev[g] = COUNT_W'(1);
			end else begin : g_link
				assign prev[g] = cnt[g-1];
			end
			dsc_cell #(
				.IDX(g),
				.LW(LW)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.count_len(len_q),
				.next_len(len_next),
				.prev_count(prev[g]),
				.count(cnt[g]),
				.sel_count(sel[g]),
				.ovf(ovf[g])
			);
		end
	endgenerate

	always_comb begin
		picked = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			picked = picked | sel[i];
		end
	end

	assign any_ovf = |ovf;
	assign flag_next = ctrl.zero_counts ? 1'b0 : (flag_q || any_ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			flag_q <= 1'b0;
		end else if (accept) begin
			len_q <= len_next;
			flag_q <= flag_next;
		end
	end

	always_comb begin
		res.match_count = (len_next == '0) ? COUNT_W'(1) : picked;
		res.overflowed = flag_next;
		res.pattern_length = LEN_W'(len_next);
		res.rejected = rejected;
	end

	dsc_skid u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_data(res),
		.full(item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FULL_LEN)
		else $error("pattern length beyond store size");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rejected |-> result.pattern_length == LEN_W'(MAX_PATTERN))
		else $error("append refused while store not full");

	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.command == CMD_CLEAR || item.command == CMD_RESTART) |=> !flag_q)
		else $error("overflow flag survived clear or restart");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("request stalled with empty output register");

endmodule

[test/tb_distinct_subsequence_counter.sv]
// self-checking testbench for distinct_subsequence_counter
// depends on dsc_pkg and the block; a directed table, then random command sequences,
// checked against typed results or an in-bench prediction of the counts
module tb_distinct_subsequence_counter;

	import dsc_pkg::*;

	localparam int MAX_PAT = MAX_PATTERN_DEF;
	localparam int RANDOM_ITEMS = 1640;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PRESSURE_AT = 700;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] symbol;
		logic [7:0] reps;
		logic       known;
		result_t    want;
	} dir_row_t;

	localparam int DIR_ROWS = 20;

	// known rows carry their result; the rest are predicted
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{CMD_FEED,    8'h00, 8'd1,  1'b1, '{64'd1, 1'b0, 7'd0,  1'b0}}, // empty pattern
		'{CMD_RESTART, 8'hFF, 8'd1,  1'b1, '{64'd1, 1'b0, 7'd0,  1'b0}},
		'{CMD_CLEAR,   8'hFF, 8'd1,  1'b1, '{64'd1, 1'b0, 7'd0,  1'b0}},
		'{CMD_APPEND,  8'h00, 8'd1,  1'b1, '{64'd0, 1'b0, 7'd1,  1'b0}},
		'{CMD_APPEND,  8'hFF, 8'd1,  1'b1, '{64'd0, 1'b0, 7'd2,  1'b0}},
		'{CMD_FEED,    8'hFF, 8'd1,  1'b0, '0},
		'{CMD_FEED,    8'h00, 8'd1,  1'b0, '0},
		'{CMD_FEED,    8'hFF, 8'd1,  1'b0, '0},
		'{CMD_FEED,    8'h55, 8'd1,  1'b0, '0},
		'{CMD_FEED,    8'hAA, 8'd1,  1'b0, '0},
		'{CMD_APPEND,  8'h00, 8'd1,  1'b1, '{64'd0, 1'b0, 7'd3,  1'b0}}, // new cell starts at zero
		'{CMD_FEED,    8'h00, 8'd2,  1'b0, '0},
		'{CMD_RESTART, 8'h00, 8'd1,  1'b1, '{64'd0, 1'b0, 7'd3,  1'b0}},
		'{CMD_CLEAR,   8'h00, 8'd1,  1'b1, '{64'd1, 1'b0, 7'd0,  1'b0}},
		'{CMD_APPEND,  8'h61, 8'd64, 1'b0, '0},
		'{CMD_APPEND,  8'h62, 8'd2,  1'b1, '{64'd0, 1'b0, 7'd64, 1'b1}}, // store full
		'{CMD_FEED,    8'h61, 8'd72, 1'b0, '0},                          // drives cells to saturation
		'{CMD_RESTART, 8'h61, 8'd1,  1'b1, '{64'd0, 1'b0, 7'd64, 1'b0}},
		'{CMD_FEED,    8'h61, 8'd1,  1'b0, '0},
		'{CMD_CLEAR,   8'h00, 8'd1,  1'b1, '{64'd1, 1'b0, 7'd0,  1'b0}}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	distinct_subsequence_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request list, with typed results for some directed rows
	item_t   req_list[$];
	bit      req_known[$];
	result_t req_want[$];

	// predicted block state
	logic [7:0]         pat_sym[MAX_PAT];
	int                 pat_len = 0;
	logic [COUNT_W-1:0] cell_cnt[MAX_PAT];
	bit                 sticky_ovf = 1'b0;

	result_t pending_counts[$];
	int      accepted_count = 0;
	int      checked_count = 0;
	int      mismatch_count = 0;
	int      saturated_seen = 0;
	int      rejected_seen = 0;
	int      cycle_count = 0;

	function automatic void add_request(input cmd_t c, input logic [7:0] s);
		item_t r;
		r.command = c;
		r.symbol = s;
		req_list.push_back(r);
		req_known.push_back(1'b0);
		req_want.push_back('0);
	endfunction

	function automatic logic [7:0] alphabet_symbol(input int base, input int span);
		return 8'(base + $urandom_range(0, span - 1));
	endfunction

	function automatic result_t count_step(input item_t req);
		result_t            res;
		logic [COUNT_W:0]   sum;
		logic [COUNT_W-1:0] below;
		res = '0;
		if (req.command == CMD_CLEAR || req.command == CMD_RESTART) begin
			foreach (cell_cnt[k]) cell_cnt[k] = '0;
			sticky_ovf = 1'b0;
		end
		case (req.command)
			CMD_CLEAR: begin
				pat_len = 0;
			end
			CMD_APPEND: begin
				if (pat_len >= MAX_PAT) begin
					res.rejected = 1'b1;
				end else begin
					pat_sym[pat_len] = req.symbol;
					cell_cnt[pat_len] = '0;
					pat_len++;
				end
			end
			CMD_FEED: begin
				// top down so each cell adds its neighbor's old count
				for (int k = pat_len - 1; k >= 0; k--) begin
					if (pat_sym[k] == req.symbol) begin
						below = (k == 0) ? COUNT_W'(1) : cell_cnt[k-1];
						sum = {1'b0, cell_cnt[k]} + {1'b0, below};
						if (sum[COUNT_W]) begin
							cell_cnt[k] = '1;
							sticky_ovf = 1'b1;
						end else begin
							cell_cnt[k] = sum[COUNT_W-1:0];
						end
					end
				end
			end
			default: ;
		endcase
		res.match_count = (pat_len == 0) ? COUNT_W'(1) : cell_cnt[pat_len-1];
		res.overflowed = sticky_ovf;
		res.pattern_length = 7'(pat_len);
		return res;
	endfunction

	initial begin
		int   kind, base, span, n, r;
		cmd_t c;
		foreach (cell_cnt[k]) cell_cnt[k] = '0;
		foreach (pat_sym[k]) pat_sym[k] = '0;
		foreach (DIRECTED[i]) begin
			for (int j = 0; j < DIRECTED[i].reps; j++) begin
				add_request(DIRECTED[i].command, DIRECTED[i].symbol);
				req_known[$] = DIRECTED[i].known;
				req_want[$] = DIRECTED[i].want;
			end
		end
		n = req_list.size();
		while (req_list.size() < n + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			base = $urandom_range(0, 255);
			span = $urandom_range(2, 4);
			if (kind < 60) begin
				// pattern over a small alphabet, then a source stream over it
				add_request(($urandom_range(0, 3) == 0) ? CMD_RESTART : CMD_CLEAR,
					8'($urandom_range(0, 255)));
				r = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
				repeat (r) add_request(CMD_APPEND, alphabet_symbol(base, span));
				repeat ($urandom_range(10, 40)) begin
					r = $urandom_range(0, 99);
					if (r < 3)
						add_request(CMD_RESTART, 8'($urandom_range(0, 255)));
					else if (r < 7)
						add_request(CMD_APPEND, alphabet_symbol(base, span));
					else if (r >= 97)
						add_request(CMD_FEED, 8'($urandom_range(0, 255)));
					else
						add_request(CMD_FEED, alphabet_symbol(base, span));
				end
			end else if (kind < 70) begin
				// long run of one symbol against a long uniform pattern saturates
				add_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
				repeat ($urandom_range(30, 48)) add_request(CMD_APPEND, 8'(base));
				repeat ($urandom_range(72, 96)) begin
					if ($urandom_range(0, 19) == 0)
						add_request(CMD_FEED, alphabet_symbol(base, span));
					else
						add_request(CMD_FEED, 8'(base));
				end
			end else if (kind < 78) begin
				add_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
				repeat (MAX_PAT + $urandom_range(1, 4))
					add_request(CMD_APPEND, alphabet_symbol(base, span));
				repeat (20) add_request(CMD_FEED, alphabet_symbol(base, span));
			end else begin
				repeat ($urandom_range(5, 20)) begin
					c = cmd_t'($urandom_range(0, 3));
					add_request(c, 8'($urandom_range(0, 255)));
				end
			end
		end
	end

	// sender: bursts of requests with random gaps
	int next_req = 0;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && (!item_valid || !item_stall)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (next_req < req_list.size()) begin
				item_valid <= 1'b1;
				item <= req_list[next_req];
				next_req++;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 99);
					gap_left = (gap_left < 40) ? 0 :
						(gap_left < 90) ? $urandom_range(1, 4) : $urandom_range(8, 25);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern changes every so often, plus one long hold-off
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          hold_left = 0;
	bit          held_once = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!held_once && accepted_count >= PRESSURE_AT) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 150);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					STALL_NONE:     result_stall <= 1'b0;
					STALL_LIGHT:    result_stall <= ($urandom_range(0, 99) < 30);
					STALL_PERIODIC: result_stall <= (cycle_count % 3 == 0);
					STALL_HEAVY:    result_stall <= ($urandom_range(0, 99) < 75);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				want = count_step(item);
				if (req_known[accepted_count])
					want = req_want[accepted_count];
				pending_counts.push_back(want);
				accepted_count++;
			end
			if (result_valid && !result_stall) begin
				got = result;
				if (pending_counts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected result count=%0d ovf=%0b len=%0d rej=%0b",
							got.match_count, got.overflowed, got.pattern_length, got.rejected);
				end else begin
					want = pending_counts.pop_front();
					checked_count++;
					if (got.overflowed === 1'b1) saturated_seen++;
					if (got.rejected === 1'b1) rejected_seen++;
					if (got.match_count !== want.match_count
						|| got.overflowed !== want.overflowed
						|| got.pattern_length !== want.pattern_length
						|| got.rejected !== want.rejected) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display({"result %0d: want count=%0d ovf=%0b len=%0d rej=%0b,",
								" got count=%0d ovf=%0b len=%0d rej=%0b"},
								checked_count - 1, want.match_count, want.overflowed,
								want.pattern_length, want.rejected, got.match_count,
								got.overflowed, got.pattern_length, got.rejected);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_counts.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		while (accepted_count < req_list.size()) @(posedge clk);
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests, %0d results checked, %0d mismatches", accepted_count,
			checked_count, mismatch_count);
		$display("%0d results with saturation flagged, %0d refused appends", saturated_seen,
			rejected_seen);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
